// File: design/pqe_pkg.sv
// ----------------------------------------------------------------------------
// Pooled queue package
// Sizes, codes, word types and helpers shared by the pooled queue design.
// ----------------------------------------------------------------------------
package pqe_pkg;

	localparam int POOL_DEPTH   = 64;
	localparam int HANDLE_WIDTH = 32;

	localparam int IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int LINK_W = $clog2(POOL_DEPTH + 1);
	localparam int CNT_W  = LINK_W;

	localparam int REQ_W = 2;
	localparam int DH_W  = 32;
	localparam int ST_W  = 2;
	localparam int OCC_W = 7;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [LINK_W-1:0]       link_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [HANDLE_WIDTH-1:0] handle_t;

	localparam link_t NULL_LINK = link_t'(POOL_DEPTH);

	localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_ERASE = 2'd2;

	localparam logic [ST_W-1:0] ST_DONE = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_MISS = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [DH_W-1:0]  data_handle;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic             front_valid;
		logic [DH_W-1:0]  front_handle;
		logic             back_valid;
		logic [DH_W-1:0]  back_handle;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

	function automatic logic is_node(input link_t l);
		return l < NULL_LINK;
	endfunction

endpackage

// File: design/pqe_req_if.sv
// ----------------------------------------------------------------------------
// Pooled queue request channel
// Valid/ready channel that carries one request word.
// ----------------------------------------------------------------------------
interface pqe_req_if;
	import pqe_pkg::*;

	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: design/pqe_rsp_if.sv
// ----------------------------------------------------------------------------
// Pooled queue response channel
// Valid/ready channel that carries one response word.
// ----------------------------------------------------------------------------
interface pqe_rsp_if;
	import pqe_pkg::*;

	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: design/pqe_ram.sv
// ----------------------------------------------------------------------------
// Pooled queue RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pqe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/pooled_queue_with_erase_core.sv
// ----------------------------------------------------------------------------
// Pooled queue with erase
// FIFO of handles kept as a doubly linked list in a fixed node pool.
// ----------------------------------------------------------------------------
// The req channel takes one word: a request type (push, pop or erase) and a
// handle. The rsp channel returns one word per request: the status, the front
// and back handles with their valid flags, and the occupancy afterwards.
// Requests are processed one at a time, and each response is registered in
// S_FIN. A push reads a node from the free stack in S_PUSH_RD unless it takes
// a fresh node, writes the node in S_PUSH_W1 and, onto a non-empty queue,
// links the old tail to it in S_PUSH_W2. A pop reads the head in S_POP_RD; an
// erase walks from the head in S_ER_WALK until it finds a match, reaches the
// tail or has visited as many nodes as the occupancy. The walk visits one node
// per cycle, bounded by the registered read of the payload and link memories.
// Full, empty and no-op requests go straight to S_FIN. Pops and successful
// erases end with two reads that refresh the cached front and back handles.
// After reset the queue is empty and every node is free; no clearing pass is
// needed. A response waits in its output register while the receiver stalls;
// the next request is accepted meanwhile, and its own response waits until
// the register is free.
// ----------------------------------------------------------------------------
module pooled_queue_with_erase_core (
	input  logic       clk,
	input  logic       arst_n,
	pqe_req_if.sink    req,
	pqe_rsp_if.source  rsp
);
	import pqe_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH_RD,
		S_PUSH_W1,
		S_PUSH_W2,
		S_POP_RD,
		S_ER_WALK,
		S_RF0,
		S_RF1,
		S_RF2,
		S_FIN
	} state_t;

	state_t          state_q;
	link_t           head_q;
	link_t           tail_q;
	cnt_t            free_cnt_q;
	cnt_t            wm_q;
	cnt_t            entry_cnt_q;
	cnt_t            steps_q;
	idx_t            node_q;
	handle_t         h_q;
	handle_t         hd_hdl_q;
	handle_t         tl_hdl_q;
	logic [ST_W-1:0] st_q;
	logic            rsp_vld_q;
	rsp_t            rsp_q;

	logic    acc;
	logic    match;
	logic    walk_more;
	logic    fs_room;
	idx_t    rd_idx;
	handle_t pl_rdata;
	link_t   nx_rdata;
	link_t   pv_rdata;
	idx_t    fs_rdata;
	logic    pl_we;
	logic    nx_we;
	logic    pv_we;
	logic    fs_we;
	idx_t    nx_waddr;
	idx_t    pv_waddr;
	link_t   nx_wdata;
	link_t   pv_wdata;

	function automatic handle_t to_store(input logic [DH_W-1:0] x);
		handle_t r;
		r = '0;
		for (int i = 0; i < HANDLE_WIDTH && i < DH_W; i++) begin
			r[i] = x[i];
		end
		return r;
	endfunction

	function automatic logic [DH_W-1:0] from_store(input handle_t x);
		logic [DH_W-1:0] r;
		r = '0;
		for (int i = 0; i < HANDLE_WIDTH && i < DH_W; i++) begin
			r[i] = x[i];
		end
		return r;
	endfunction

	function automatic logic [OCC_W-1:0] to_occ(input cnt_t c);
		logic [OCC_W-1:0] r;
		r = '0;
		for (int i = 0; i < CNT_W && i < OCC_W; i++) begin
			r[i] = c[i];
		end
		return r;
	endfunction

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_vld_q;
	assign rsp.payload = rsp_q;

	assign match     = (pl_rdata == h_q);
	assign walk_more = is_node(nx_rdata) &&
		(({1'b0, steps_q} + (CNT_W+1)'(1)) < {1'b0, entry_cnt_q});
	assign fs_room   = (free_cnt_q < cnt_t'(POOL_DEPTH));

	always_comb begin
		unique case (state_q)
			S_IDLE:    rd_idx = idx_t'(head_q);
			S_ER_WALK: rd_idx = idx_t'(nx_rdata);
			S_RF0:     rd_idx = idx_t'(head_q);
			S_RF1:     rd_idx = idx_t'(tail_q);
			default:   rd_idx = node_q;
		endcase
	end

	always_comb begin
		pl_we    = 1'b0;
		nx_we    = 1'b0;
		pv_we    = 1'b0;
		fs_we    = 1'b0;
		nx_waddr = node_q;
		pv_waddr = node_q;
		nx_wdata = NULL_LINK;
		pv_wdata = NULL_LINK;
		unique case (state_q)
			S_PUSH_W1: begin
				pl_we    = 1'b1;
				nx_we    = 1'b1;
				pv_we    = 1'b1;
				pv_wdata = tail_q;
			end
			S_PUSH_W2: begin
				nx_we    = 1'b1;
				nx_waddr = idx_t'(tail_q);
				nx_wdata = link_t'(node_q);
			end
			S_POP_RD: begin
				pv_we    = is_node(nx_rdata);
				pv_waddr = idx_t'(nx_rdata);
				fs_we    = fs_room;
			end
			S_ER_WALK: begin
				if (match) begin
					nx_we    = is_node(pv_rdata);
					nx_waddr = idx_t'(pv_rdata);
					nx_wdata = nx_rdata;
					pv_we    = is_node(nx_rdata);
					pv_waddr = idx_t'(nx_rdata);
					pv_wdata = pv_rdata;
					fs_we    = fs_room;
				end
			end
			default: begin
			end
		endcase
	end

	pqe_ram #(.WIDTH(HANDLE_WIDTH), .DEPTH(POOL_DEPTH)) u_payload (
		.clk   (clk),
		.we    (pl_we),
		.waddr (node_q),
		.wdata (h_q),
		.raddr (rd_idx),
		.rdata (pl_rdata)
	);

	pqe_ram #(.WIDTH(LINK_W), .DEPTH(POOL_DEPTH)) u_next (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.raddr (rd_idx),
		.rdata (nx_rdata)
	);

	pqe_ram #(.WIDTH(LINK_W), .DEPTH(POOL_DEPTH)) u_prev (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_waddr),
		.wdata (pv_wdata),
		.raddr (rd_idx),
		.rdata (pv_rdata)
	);

	// Stack slots below the low watermark were never written and hold no valid
	// node index, so a push at the watermark takes a fresh node.
	pqe_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_free (
		.clk   (clk),
		.we    (fs_we),
		.waddr (idx_t'(free_cnt_q)),
		.wdata (node_q),
		.raddr (idx_t'(free_cnt_q - cnt_t'(1))),
		.rdata (fs_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= NULL_LINK;
			tail_q      <= NULL_LINK;
			free_cnt_q  <= cnt_t'(POOL_DEPTH);
			wm_q        <= cnt_t'(POOL_DEPTH);
			entry_cnt_q <= '0;
			rsp_vld_q   <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready && state_q != S_FIN) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						h_q  <= to_store(req.payload.data_handle);
						case (req.payload.req_type)
							REQ_PUSH: begin
								if (free_cnt_q == '0) begin
									st_q    <= ST_FULL;
									state_q <= S_FIN;
								end else begin
									st_q       <= ST_DONE;
									free_cnt_q <= free_cnt_q - cnt_t'(1);
									if (free_cnt_q == wm_q) begin
										node_q  <= idx_t'(cnt_t'(POOL_DEPTH) - free_cnt_q);
										wm_q    <= wm_q - cnt_t'(1);
										state_q <= S_PUSH_W1;
									end else begin
										state_q <= S_PUSH_RD;
									end
								end
							end
							REQ_POP: begin
								if (!is_node(head_q)) begin
									st_q    <= ST_MISS;
									state_q <= S_FIN;
								end else begin
									st_q    <= ST_DONE;
									node_q  <= idx_t'(head_q);
									state_q <= S_POP_RD;
								end
							end
							REQ_ERASE: begin
								if (!is_node(head_q) || entry_cnt_q == '0) begin
									st_q    <= ST_MISS;
									state_q <= S_FIN;
								end else begin
									st_q    <= ST_DONE;
									node_q  <= idx_t'(head_q);
									steps_q <= '0;
									state_q <= S_ER_WALK;
								end
							end
							default: begin
								st_q    <= ST_DONE;
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_PUSH_RD: begin
					node_q  <= fs_rdata;
					state_q <= S_PUSH_W1;
				end
				S_PUSH_W1: begin
					entry_cnt_q <= entry_cnt_q + cnt_t'(1);
					tl_hdl_q    <= h_q;
					if (!is_node(head_q)) begin
						head_q   <= link_t'(node_q);
						tail_q   <= link_t'(node_q);
						hd_hdl_q <= h_q;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_PUSH_W2;
					end
				end
				S_PUSH_W2: begin
					tail_q  <= link_t'(node_q);
					state_q <= S_FIN;
				end
				S_POP_RD: begin
					head_q <= nx_rdata;
					if (!is_node(nx_rdata)) begin
						tail_q <= NULL_LINK;
					end
					if (fs_room) begin
						free_cnt_q <= free_cnt_q + cnt_t'(1);
					end
					if (entry_cnt_q != '0) begin
						entry_cnt_q <= entry_cnt_q - cnt_t'(1);
					end
					state_q <= S_RF0;
				end
				S_ER_WALK: begin
					if (match) begin
						if (!is_node(pv_rdata)) begin
							head_q <= nx_rdata;
						end
						if (!is_node(nx_rdata)) begin
							tail_q <= pv_rdata;
						end
						if (fs_room) begin
							free_cnt_q <= free_cnt_q + cnt_t'(1);
						end
						if (entry_cnt_q != '0) begin
							entry_cnt_q <= entry_cnt_q - cnt_t'(1);
						end
						state_q <= S_RF0;
					end else if (walk_more) begin
						node_q  <= idx_t'(nx_rdata);
						steps_q <= steps_q + cnt_t'(1);
					end else begin
						st_q    <= ST_MISS;
						state_q <= S_FIN;
					end
				end
				S_RF0: begin
					state_q <= S_RF1;
				end
				S_RF1: begin
					hd_hdl_q <= pl_rdata;
					state_q  <= S_RF2;
				end
				S_RF2: begin
					tl_hdl_q <= pl_rdata;
					state_q  <= S_FIN;
				end
				S_FIN: begin
					if (!rsp_vld_q || rsp.ready) begin
						rsp_vld_q           <= 1'b1;
						rsp_q.status        <= st_q;
						rsp_q.front_valid   <= is_node(head_q);
						rsp_q.front_handle  <= is_node(head_q) ? from_store(hd_hdl_q) : '0;
						rsp_q.back_valid    <= is_node(tail_q);
						rsp_q.back_handle   <= is_node(tail_q) ? from_store(tl_hdl_q) : '0;
						rsp_q.occupancy     <= to_occ(entry_cnt_q);
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pool_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
		(({1'b0, free_cnt_q} + {1'b0, entry_cnt_q}) == (CNT_W+1)'(POOL_DEPTH)))
		else $error("free and used node counts do not add up to the pool size");

	a_ends_agree: assert property (@(posedge clk) disable iff (!arst_n)
		is_node(head_q) == is_node(tail_q))
		else $error("head and tail disagree on an empty list");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(entry_cnt_q == '0) == !is_node(head_q))
		else $error("entry count disagrees with the head pointer");

	a_watermark: assert property (@(posedge clk) disable iff (!arst_n)
		wm_q <= free_cnt_q)
		else $error("free stack watermark above the free count");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !req.ready)
		else $error("second request accepted while one is in progress");
`endif
endmodule

// File: bench/pooled_queue_with_erase_core_tb.sv
// ----------------------------------------------------------------------------
// Pooled queue with erase testbench
// Drives push, pop, erase and no-op requests into the queue core with random
// idling on both channels. It keeps a list of the handles it expects the
// queue to hold, predicts the response word for every accepted request, and
// compares each returned word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pooled_queue_with_erase_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pqe_pkg::*;

	localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 150;

	logic clk;
	logic arst_n;

	pqe_req_if req_ch ();
	pqe_rsp_if rsp_ch ();

	pooled_queue_with_erase_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	handle_t held_handles[$];
	rsp_t    expected_rsps[$];

	int src_gap_pct    = 0;
	int sink_stall_pct = 0;
	int mismatches     = 0;
	int checked_rsps   = 0;
	int idle_cycles    = 0;
	int req_counts[4]  = '{0, 0, 0, 0};
	int full_seen      = 0;
	int miss_seen      = 0;
	int peak_occupancy = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic rsp_t predict_response(input req_t word);
		rsp_t    want;
		handle_t h;
		int      hit;
		h = handle_t'(word.data_handle);
		want = '0;
		want.status = ST_DONE;
		hit = -1;
		case (word.req_type)
		REQ_PUSH: begin
			if (held_handles.size() >= POOL_DEPTH)
				want.status = ST_FULL;
			else
				held_handles.insert(held_handles.size(), h);
		end
		REQ_POP: begin
			if (held_handles.size() == 0)
				want.status = ST_MISS;
			else
				held_handles.delete(0);
		end
		REQ_ERASE: begin
			foreach (held_handles[i])
				if (hit < 0 && held_handles[i] == h)
					hit = i;
			if (hit < 0)
				want.status = ST_MISS;
			else
				held_handles.delete(hit);
		end
		default: ;
		endcase
		if (held_handles.size() > 0) begin
			want.front_valid  = 1'b1;
			want.front_handle = DH_W'(held_handles[0]);
			want.back_valid   = 1'b1;
			want.back_handle  = DH_W'(held_handles[$]);
		end
		want.occupancy = OCC_W'(held_handles.size());
		return want;
	endfunction

	task automatic send_word(input logic [REQ_W-1:0] kind, input logic [DH_W-1:0] handle);
		req_t word;
		word.req_type    = kind;
		word.data_handle = handle;
		if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		req_ch.valid   = 1'b1;
		req_ch.payload = word;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		expected_rsps.insert(expected_rsps.size(), predict_response(word));
		req_counts[kind]++;
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [DH_W-1:0] want,
		input logic [DH_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("response %0d: %s expected %0h, got %0h",
					checked_rsps, name, want, got);
		end
	endtask

	task automatic pick_idling();
		src_gap_pct    = 15 * $urandom_range(0, 2);
		sink_stall_pct = 15 * $urandom_range(0, 2);
	endtask

	task automatic test_directed();
		src_gap_pct    = 20;
		sink_stall_pct = 20;
		send_word(REQ_PUSH, 32'h0000_0000);
		send_word(REQ_PUSH, 32'hFFFF_FFFF);
		send_word(REQ_PUSH, 32'h0000_0000);
		send_word(REQ_PUSH, 32'hA5A5_A5A5);
		send_word(REQ_ERASE, 32'h0000_0000);
		send_word(REQ_ERASE, 32'hA5A5_A5A5);
		send_word(REQ_ERASE, 32'h1234_5678);
		send_word(REQ_NOP, 32'hFFFF_FFFF);
		send_word(REQ_ERASE, 32'h0000_0000);
		send_word(REQ_POP, 32'hFFFF_FFFF);
		send_word(REQ_POP, 32'h0000_0000);
		send_word(REQ_ERASE, 32'h0000_0000);
		send_word(REQ_NOP, 32'h0000_0000);
		send_word(REQ_PUSH, 32'h5A5A_5A5A);
		send_word(REQ_PUSH, 32'h0000_0001);
		send_word(REQ_PUSH, 32'h8000_0000);
		send_word(REQ_ERASE, 32'h0000_0001);
		send_word(REQ_POP, 32'h0000_0000);
		send_word(REQ_POP, 32'h0000_0000);
		send_word(REQ_PUSH, 32'h0000_0007);
		send_word(REQ_ERASE, 32'h0000_0007);
	endtask

	task automatic test_full_pool();
		int k;
		pick_idling();
		while (held_handles.size() > 0)
			send_word(REQ_POP, $urandom);
		for (k = 0; k < POOL_DEPTH; k++)
			send_word(REQ_PUSH, $urandom);
		repeat (3) send_word(REQ_PUSH, $urandom);
		send_word(REQ_ERASE, held_handles[$]);
		send_word(REQ_PUSH, $urandom);
		send_word(REQ_PUSH, $urandom);
		send_word(REQ_ERASE, held_handles[POOL_DEPTH / 2]);
		send_word(REQ_ERASE, held_handles[0]);
		send_word(REQ_ERASE, $urandom);
		while (held_handles.size() > 0) begin
			if ($urandom_range(0, 2) == 0)
				send_word(REQ_POP, $urandom);
			else
				send_word(REQ_ERASE,
					held_handles[$urandom_range(0, held_handles.size() - 1)]);
		end
		send_word(REQ_POP, $urandom);
	endtask

	task automatic test_random_mix(input int count, input bit narrow_handles);
		int n;
		int roll;
		int push_pct;
		int target;
		logic [REQ_W-1:0] kind;
		logic [DH_W-1:0]  handle;
		target = 8;
		for (n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				case ($urandom_range(0, 3))
				0: target = 2;
				1: target = 12;
				2: target = 40;
				default: target = POOL_DEPTH + 4;
				endcase
			end
			push_pct = (held_handles.size() < target) ? 65 : 20;
			roll = $urandom_range(0, 99);
			handle = narrow_handles ? DH_W'($urandom_range(0, 5)) : DH_W'($urandom);
			if (roll < 3) begin
				kind = REQ_NOP;
			end else if (roll < 3 + push_pct) begin
				kind = REQ_PUSH;
			end else if (roll < 3 + push_pct + (97 - push_pct) / 2) begin
				kind = REQ_POP;
			end else begin
				kind = REQ_ERASE;
				if (held_handles.size() > 0 && $urandom_range(0, 3) != 0)
					handle = held_handles[$urandom_range(0, held_handles.size() - 1)];
			end
			send_word(kind, handle);
		end
	endtask

	initial begin : rsp_ready_driver
		int stall;
		stall = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall == 0 && sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct)
				stall = $urandom_range(1, 10);
			if (stall > 0) begin
				rsp_ch.ready = 1'b0;
				stall--;
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : rsp_checker
		rsp_t got;
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.payload;
			checked_rsps++;
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("response %0d arrived with no request waiting: %p",
						checked_rsps, got);
			end else begin
				want = expected_rsps[0];
				expected_rsps.delete(0);
				check_field("status", DH_W'(want.status), DH_W'(got.status));
				check_field("front_valid", DH_W'(want.front_valid),
					DH_W'(got.front_valid));
				check_field("front_handle", want.front_handle, got.front_handle);
				check_field("back_valid", DH_W'(want.back_valid),
					DH_W'(got.back_valid));
				check_field("back_handle", want.back_handle, got.back_handle);
				check_field("occupancy", DH_W'(want.occupancy), DH_W'(got.occupancy));
				if (want.status == ST_FULL)
					full_seen++;
				if (want.status == ST_MISS)
					miss_seen++;
				if (int'(want.occupancy) > peak_occupancy)
					peak_occupancy = int'(want.occupancy);
			end
		end
	end

	initial begin : watchdog
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin : main_sequence
		int phase;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_pool();
		for (phase = 0; phase < 4; phase++) begin
			pick_idling();
			test_random_mix(300, phase[0]);
		end
		src_gap_pct    = 0;
		sink_stall_pct = 0;
		test_random_mix(300, 1'b0);

		req_ch.valid = 1'b0;
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d pushes, %0d pops, %0d erases and %0d no-ops; checked %0d responses.",
			req_counts[REQ_PUSH], req_counts[REQ_POP], req_counts[REQ_ERASE],
			req_counts[REQ_NOP], checked_rsps);
		$display("Saw %0d dropped pushes, %0d empty or unmatched requests, peak occupancy %0d.",
			full_seen, miss_seen, peak_occupancy);
		if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches found", mismatches);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: pooled_queue_with_erase_core.f
design/pqe_pkg.sv
design/pqe_req_if.sv
design/pqe_rsp_if.sv
design/pqe_ram.sv
design/pooled_queue_with_erase_core.sv
bench/pooled_queue_with_erase_core_tb.sv
